[design/refcounted_stream_registration_table_defines.svh]
// Assertion macros for the stream registration table RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef REFCOUNTED_STREAM_REGISTRATION_TABLE_DEFINES_SVH
`define REFCOUNTED_STREAM_REGISTRATION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rsrt_pkg.sv]
// Shared types and constants for the stream registration table.
// Used by the controller, the datapath and the top level.
package rsrt_pkg;

    // Width of one stream identifier.
    localparam int KEY_BITS = 64;

    // Result status codes.
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_FULL        = 3'd1;
    localparam logic [2:0] STATUS_NOT_REG     = 3'd2;
    localparam logic [2:0] STATUS_REMOTE_FAIL = 3'd3;
    localparam logic [2:0] STATUS_SATURATED   = 3'd4;

    // Action codes.
    localparam logic ACT_REGISTER   = 1'b0;
    localparam logic ACT_DEREGISTER = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new request and restart the scan
        logic scan;    // issue one table read
        logic clr_wr;  // write one cleared entry
        logic commit;  // write back the entry and register the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // the clearing pass writes its last entry
        logic rd_last;   // the scan issues its last read
    } t_stat;

endpackage

[design/rsrt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rsrt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/rsrt_ctrl.sv]
// Controller for the stream registration table: clearing pass, scan and commit.
// Depends on rsrt_pkg and on the assertion macro header.
`include "refcounted_stream_registration_table_defines.svh"

module rsrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rsrt_pkg::t_stat i_stat,
    output rsrt_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.clr_wr = (r_state == S_CLEAR);
        o_cmd.commit = (r_state == S_COMMIT);
    end

    assign o_busy = (r_state != S_IDLE);

    // A transaction accepted in idle always starts a scan.
    `RSRT_ASSERT_NEXT(a_start_scans, i_clk, i_rst_n, (r_state == S_IDLE) && i_start, r_state == S_SCAN, "accepted request did not start a scan")
    // The scan only ends on its last read.
    `RSRT_ASSERT_NEXT(a_scan_holds, i_clk, i_rst_n, (r_state == S_SCAN) && !i_stat.rd_last, r_state == S_SCAN, "scan ended early")
    // Commit lasts one cycle and returns to idle.
    `RSRT_ASSERT_NEXT(a_commit_once, i_clk, i_rst_n, r_state == S_COMMIT, (r_state == S_IDLE) && !o_cmd.commit, "commit did not return to idle")
    // No write-back while the clearing pass runs.
    `RSRT_ASSERT_NOW(a_clear_excl, i_clk, i_rst_n, o_cmd.clr_wr, !o_cmd.commit && !o_cmd.scan, "clear overlaps other work")

endmodule

[design/rsrt_dp.sv]
// Datapath for the stream registration table: request registers, scan
// bookkeeping, count update and result registers around one table RAM.
// Depends on rsrt_pkg and rsrt_ram.
module rsrt_dp #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rsrt_pkg::t_cmd               i_cmd,
    output rsrt_pkg::t_stat              o_stat,
    input  logic                         i_action,
    input  logic                         i_table_sel,
    input  logic [rsrt_pkg::KEY_BITS-1:0] i_stream_key,
    input  logic                         i_remote_ok,
    output logic                         o_res_valid,
    output logic [2:0]                   o_status,
    output logic                         o_issue_remote,
    output logic [4:0]                   o_slot,
    output logic [7:0]                   o_count_after
);

    localparam int DEPTH = 2 * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDTH = rsrt_pkg::KEY_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Request registers.
    logic                          r_action;
    logic                          r_table;
    logic [rsrt_pkg::KEY_BITS-1:0] r_key;
    logic                          r_remote_ok;

    // Scan bookkeeping.
    logic [AW-1:0]          r_clr_addr;
    logic [IW-1:0]          r_rd_idx;
    logic [IW-1:0]          r_eval_idx;
    logic                   r_dvalid;
    logic                   r_found_match;
    logic [IW-1:0]          r_match_idx;
    logic [COUNT_BITS-1:0]  r_match_cnt;
    logic                   r_found_free;
    logic [IW-1:0]          r_free_idx;

    // Result registers.
    logic       r_res_valid;
    logic [2:0] r_status;
    logic       r_issue;
    logic [4:0] r_slot;
    logic [7:0] r_count_after;

    // RAM signals.
    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [WIDTH-1:0]              ram_wr_data;
    logic [AW-1:0]                 ram_rd_addr;
    logic [WIDTH-1:0]              ram_rd_data;
    logic [rsrt_pkg::KEY_BITS-1:0] rd_key;
    logic [COUNT_BITS-1:0]         rd_cnt;

    // Commit evaluation.
    logic                  hit;
    logic [IW-1:0]         hit_idx;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [2:0]            n_status;
    logic                  n_issue;
    logic [AW-1:0]         commit_addr;
    logic [31:0]           idx_wide;
    logic [31:0]           cnt_wide;

    rsrt_ram #(
        .WIDTH(WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (i_cmd.scan),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    assign rd_key = ram_rd_data[WIDTH-1 -: rsrt_pkg::KEY_BITS];
    assign rd_cnt = ram_rd_data[COUNT_BITS-1:0];

    // Table entries sit in the lower half for listeners, upper half for talkers.
    assign ram_rd_addr = r_table ? (AW'(ENTRIES) + AW'(r_rd_idx)) : AW'(r_rd_idx);
    assign commit_addr = r_table ? (AW'(ENTRIES) + AW'(hit_idx)) : AW'(hit_idx);

    // Status toward the controller.
    assign o_stat.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.rd_last  = (r_rd_idx == IW'(ENTRIES - 1));

    // A match wins over a free entry; a claimed entry starts at count zero.
    always_comb begin
        hit      = r_found_match || r_found_free;
        hit_idx  = r_found_match ? r_match_idx : r_free_idx;
        old_cnt  = r_found_match ? r_match_cnt : '0;
        n_cnt    = old_cnt;
        n_status = rsrt_pkg::STATUS_OK;
        n_issue  = 1'b0;
        if (!hit) begin
            n_status = (r_action == rsrt_pkg::ACT_DEREGISTER) ?
                       rsrt_pkg::STATUS_NOT_REG : rsrt_pkg::STATUS_FULL;
        end else if (r_action == rsrt_pkg::ACT_REGISTER) begin
            priority if (old_cnt == '0) begin
                n_issue = 1'b1;
                if (r_remote_ok) begin
                    n_cnt = COUNT_BITS'(1);
                end else begin
                    n_status = rsrt_pkg::STATUS_REMOTE_FAIL;
                end
            end else if (old_cnt == CNT_MAX) begin
                n_status = rsrt_pkg::STATUS_SATURATED;
            end else begin
                n_cnt = old_cnt + COUNT_BITS'(1);
            end
        end else begin
            if (old_cnt == '0) begin
                n_status = rsrt_pkg::STATUS_NOT_REG;
            end else begin
                n_cnt = old_cnt - COUNT_BITS'(1);
                if (old_cnt == COUNT_BITS'(1)) begin
                    n_issue = 1'b1;
                end
            end
        end
        idx_wide = 32'(hit_idx);
        cnt_wide = 32'(n_cnt);
    end

    // Write port: clearing pass or write-back of the chosen entry.
    always_comb begin
        if (i_cmd.clr_wr) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = i_cmd.commit && hit;
            ram_wr_addr = commit_addr;
            ram_wr_data = {r_key, n_cnt};
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_action;
            r_table     <= i_table_sel;
            r_key       <= i_stream_key;
            r_remote_ok <= i_remote_ok;
        end
    end

    // Clear address, read index and scan flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_rd_idx      <= '0;
            r_dvalid      <= 1'b0;
            r_found_match <= 1'b0;
            r_found_free  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_dvalid <= i_cmd.scan;
            if (i_cmd.load) begin
                r_rd_idx      <= '0;
                r_found_match <= 1'b0;
                r_found_free  <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_rd_idx <= r_rd_idx + IW'(1);
                end
                if (r_dvalid) begin
                    if (!r_found_match && (rd_key == r_key)) begin
                        r_found_match <= 1'b1;
                    end
                    if (!r_found_free && (rd_cnt == '0)) begin
                        r_found_free <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload of the first match and first free entry seen.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_eval_idx <= r_rd_idx;
        end
        if (r_dvalid && !i_cmd.load) begin
            if (!r_found_match && (rd_key == r_key)) begin
                r_match_idx <= r_eval_idx;
                r_match_cnt <= rd_cnt;
            end
            if (!r_found_free && (rd_cnt == '0)) begin
                r_free_idx <= r_eval_idx;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.commit;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= n_status;
            r_issue       <= hit && n_issue;
            r_slot        <= hit ? idx_wide[4:0] : 5'd0;
            r_count_after <= hit ? cnt_wide[7:0] : 8'd0;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_status       = r_status;
    assign o_issue_remote = r_issue;
    assign o_slot         = r_slot;
    assign o_count_after  = r_count_after;

endmodule

[design/refcounted_stream_registration_table.sv]
// Top level of the reference-counted stream registration table.
// Depends on rsrt_pkg, rsrt_ctrl, rsrt_dp and rsrt_ram.
//
// Usage:
//   A request is a transaction accepted at a rising edge with start high and
//   busy low: i_action, i_table_sel, i_stream_key and i_remote_ok are sampled
//   there. The block scans the selected table of ENTRIES entries, one RAM
//   read per cycle, records the first key match and the first free entry,
//   then writes the chosen entry, if there is one, back in one commit cycle.
//   The result (o_status, o_issue_remote, o_slot, o_count_after) is shown for
//   exactly one cycle with o_result_valid high, after the scan, drain and
//   commit states and the result register, and is taken at the edge that
//   ends that cycle. Busy falls in that same cycle, so a new request may be
//   accepted at that edge. The scan reads the table through the single
//   read port of its RAM.
//   The receiver cannot stall; each result must be taken in its cycle.
//   After reset a clearing pass writes all 2 * ENTRIES entries to zero, one
//   per cycle, with busy held high for the whole pass.
module refcounted_stream_registration_table #(
    parameter int ENTRIES    = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic                          i_table_sel,
    input  logic [rsrt_pkg::KEY_BITS-1:0] i_stream_key,
    input  logic                          i_remote_ok,
    output logic                          o_result_valid,
    output logic [2:0]                    o_status,
    output logic                          o_issue_remote,
    output logic [4:0]                    o_slot,
    output logic [7:0]                    o_count_after
);

    rsrt_pkg::t_cmd  cmd;
    rsrt_pkg::t_stat stat;

    // Sequencing of clear, scan and commit.
    rsrt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    // Table storage, lookup bookkeeping and result registers.
    rsrt_dp #(
        .ENTRIES   (ENTRIES),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_table_sel   (i_table_sel),
        .i_stream_key  (i_stream_key),
        .i_remote_ok   (i_remote_ok),
        .o_res_valid   (o_result_valid),
        .o_status      (o_status),
        .o_issue_remote(o_issue_remote),
        .o_slot        (o_slot),
        .o_count_after (o_count_after)
    );

endmodule
